// ----- sv/kcl_pkg.sv -----
// Package for the keypad code lock controller: field widths, key and mode
// codes, event codes and register reset values.
// No dependencies; every other file of the block uses it by scoped names.
package kcl_pkg;

    // Field widths of the input and result words
    localparam int MODE_W  = 2;
    localparam int KEY_W   = 8;
    localparam int EVENT_W = 4;
    localparam int COUNT_W = 3;
    localparam int SEC_W   = 16;
    localparam int ERR_W   = 4;
    localparam int DIGIT_W = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ERRORS       = 2'd0,
        CFG_LOCK_SECONDS     = 2'd1,
        CFG_ADMIN_IDLE_LIMIT = 2'd2
    } t_cfg_idx;

    // Word kinds on the input channel
    typedef enum logic [MODE_W-1:0] {
        MODE_KEY       = 2'd0,
        MODE_TICK      = 2'd1,
        MODE_IDLE_TICK = 2'd2
    } t_mode;

    // Key codes (ASCII)
    localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;
    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;
    localparam logic [KEY_W-1:0] KEY_ENTER = 8'h45;
    localparam logic [KEY_W-1:0] KEY_BACK  = 8'h42;
    localparam logic [KEY_W-1:0] KEY_ADMIN = 8'h4D;

    // Result events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE          = 4'd0,
        EV_DIGIT         = 4'd1,
        EV_BACK          = 4'd2,
        EV_UNLOCKED      = 4'd3,
        EV_WRONG         = 4'd4,
        EV_SHORT         = 4'd5,
        EV_LOCKED        = 4'd6,
        EV_COUNTDOWN     = 4'd7,
        EV_RELEASED      = 4'd8,
        EV_ADMIN_IN      = 4'd9,
        EV_ADMIN_DIGIT   = 4'd10,
        EV_CODE_UPDATED  = 4'd11,
        EV_ADMIN_REJECT  = 4'd12,
        EV_ADMIN_EXIT    = 4'd13,
        EV_ADMIN_TIMEOUT = 4'd14
    } t_event;

    // Register reset values and counter limits
    localparam logic [ERR_W-1:0] MAX_ERRORS_RST       = 4'd3;
    localparam logic [SEC_W-1:0] LOCK_SECONDS_RST     = 16'd30;
    localparam logic [SEC_W-1:0] ADMIN_IDLE_LIMIT_RST = 16'd1500;
    localparam logic [ERR_W-1:0] ERR_SAT              = 4'hF;
    localparam logic [SEC_W-1:0] IDLE_SAT             = 16'hFFFF;
    localparam int               DEFAULT_CODE_DIGITS  = 6;

endpackage

// ----- sv/kcl_in_if.sv -----
// Input channel of the keypad code lock: valid/ready handshake with a
// mode and a key code. Depends on kcl_pkg for field widths.
interface kcl_in_if;
    logic                         valid;
    logic                         ready;
    logic [kcl_pkg::MODE_W-1:0]   mode;
    logic [kcl_pkg::KEY_W-1:0]    key_code;

    modport source (output valid, output mode, output key_code, input ready);
    modport sink   (input valid, input mode, input key_code, output ready);
endinterface

// ----- sv/kcl_out_if.sv -----
// Result channel of the keypad code lock: valid/ready handshake with the
// event code and a status snapshot. Depends on kcl_pkg for field widths.
interface kcl_out_if;
    logic                          valid;
    logic                          ready;
    logic [kcl_pkg::EVENT_W-1:0]   event_res;
    logic [kcl_pkg::COUNT_W-1:0]   entry_count;
    logic                          locked;
    logic [kcl_pkg::SEC_W-1:0]     lock_remaining;
    logic                          admin_active;
    logic [kcl_pkg::ERR_W-1:0]     errors_so_far;

    modport source (output valid, output event_res, output entry_count,
                    output locked, output lock_remaining, output admin_active,
                    output errors_so_far, input ready);
    modport sink   (input valid, input event_res, input entry_count,
                    input locked, input lock_remaining, input admin_active,
                    input errors_so_far, output ready);
endinterface

// ----- sv/keypad_code_lock_controller_unit.sv -----
// Keypad code lock controller: top level, one word in gives one word out.
// Depends on kcl_pkg, kcl_in_if and kcl_out_if.
//
// Each accepted word (key press, one-second tick or admin idle tick) yields
// exactly one result word with an event code and the lock status after the
// event. A word is held in the input register and then processed into the
// result register. A new word is taken every cycle as long as results are
// drained; a result that waits holds one more word in the input register
// before ready drops. The full CODE_LEN-digit compare is done in parallel.
// Configuration registers are written directly and take effect on the
// next word; there is no clearing pass after reset.
module keypad_code_lock_controller_unit #(
    parameter int CODE_LEN = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kcl_in_if.sink                           i_in,
    kcl_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LW = $clog2(CODE_LEN + 1);
    localparam logic [LW-1:0] FULL_LEN = LW'(CODE_LEN);

    // Configuration registers
    logic [kcl_pkg::ERR_W-1:0] r_max_err;
    logic [kcl_pkg::SEC_W-1:0] r_lock_sec;
    logic [kcl_pkg::SEC_W-1:0] r_idle_lim;

    // Input register
    logic                        r_in_vld;
    logic [kcl_pkg::MODE_W-1:0]  r_mode;
    logic [kcl_pkg::KEY_W-1:0]   r_key;

    // Lock state
    logic [kcl_pkg::DIGIT_W-1:0] r_stored [CODE_LEN];
    logic [kcl_pkg::DIGIT_W-1:0] r_entry  [CODE_LEN];
    logic [kcl_pkg::DIGIT_W-1:0] r_new    [CODE_LEN];
    logic [LW-1:0]               r_entry_len, n_entry_len;
    logic [LW-1:0]               r_new_len, n_new_len;
    logic                        r_admin, n_admin;
    logic [kcl_pkg::SEC_W-1:0]   r_idle, n_idle;
    logic [kcl_pkg::ERR_W-1:0]   r_wrong, n_wrong;
    logic                        r_lock, n_lock;
    logic [kcl_pkg::SEC_W-1:0]   r_lock_left, n_lock_left;

    // Result register
    logic                        r_out_vld;
    kcl_pkg::t_event             r_ev;
    logic [kcl_pkg::COUNT_W-1:0] r_count;
    logic                        r_out_lock;
    logic [kcl_pkg::SEC_W-1:0]   r_out_left;
    logic                        r_out_admin;
    logic [kcl_pkg::ERR_W-1:0]   r_out_err;

    logic                        advance;
    kcl_pkg::t_event             ev;
    logic                        wr_entry, wr_new, code_upd;
    logic                        is_digit, match;
    logic [kcl_pkg::KEY_W-1:0]   key_off;
    logic [kcl_pkg::DIGIT_W-1:0] digit;
    logic [kcl_pkg::ERR_W-1:0]   wrong_inc;
    logic [kcl_pkg::SEC_W-1:0]   idle_inc;
    logic [LW-1:0]               shown_len;
    logic [LW+2:0]               shown_len_ext;

    // Process the held word when the result register is free or drains
    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    // Key decode
    assign key_off  = r_key - kcl_pkg::KEY_ZERO;
    assign digit    = key_off[kcl_pkg::DIGIT_W-1:0];
    assign is_digit = (r_key >= kcl_pkg::KEY_ZERO) && (r_key <= kcl_pkg::KEY_NINE);

    // Compare the whole entry against the stored code
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < CODE_LEN; i++) begin
            if (r_entry[i] != r_stored[i]) begin
                match = 1'b0;
            end
        end
    end

    assign wrong_inc = (r_wrong == kcl_pkg::ERR_SAT) ? r_wrong
                                                     : r_wrong + kcl_pkg::ERR_W'(1);
    assign idle_inc  = (r_idle == kcl_pkg::IDLE_SAT) ? r_idle
                                                     : r_idle + kcl_pkg::SEC_W'(1);

    // Next state and event for the held word
    always_comb begin
        n_entry_len = r_entry_len;
        n_new_len   = r_new_len;
        n_admin     = r_admin;
        n_idle      = r_idle;
        n_wrong     = r_wrong;
        n_lock      = r_lock;
        n_lock_left = r_lock_left;
        ev          = kcl_pkg::EV_NONE;
        wr_entry    = 1'b0;
        wr_new      = 1'b0;
        code_upd    = 1'b0;
        unique case (r_mode)
            kcl_pkg::MODE_KEY: begin
                if (!r_lock && r_key != kcl_pkg::KEY_NONE) begin
                    if (r_admin) begin
                        // Code change: any key restarts the idle count
                        n_idle = '0;
                        if (is_digit) begin
                            if (r_new_len < FULL_LEN) begin
                                wr_new    = 1'b1;
                                n_new_len = r_new_len + LW'(1);
                                ev        = kcl_pkg::EV_ADMIN_DIGIT;
                            end
                        end else if (r_key == kcl_pkg::KEY_ENTER) begin
                            if (r_new_len == FULL_LEN) begin
                                code_upd    = 1'b1;
                                n_admin     = 1'b0;
                                n_new_len   = '0;
                                n_entry_len = '0;
                                ev          = kcl_pkg::EV_CODE_UPDATED;
                            end else begin
                                n_new_len = '0;
                                ev        = kcl_pkg::EV_ADMIN_REJECT;
                            end
                        end else if (r_key == kcl_pkg::KEY_BACK) begin
                            if (r_new_len != '0) begin
                                n_new_len = r_new_len - LW'(1);
                                ev        = kcl_pkg::EV_BACK;
                            end
                        end else if (r_key == kcl_pkg::KEY_ADMIN) begin
                            n_admin     = 1'b0;
                            n_new_len   = '0;
                            n_entry_len = '0;
                            ev          = kcl_pkg::EV_ADMIN_EXIT;
                        end
                    end else begin
                        // Normal entry
                        if (is_digit) begin
                            if (r_entry_len < FULL_LEN) begin
                                wr_entry    = 1'b1;
                                n_entry_len = r_entry_len + LW'(1);
                                ev          = kcl_pkg::EV_DIGIT;
                            end
                        end else if (r_key == kcl_pkg::KEY_ENTER) begin
                            n_entry_len = '0;
                            if (r_entry_len != FULL_LEN) begin
                                ev = kcl_pkg::EV_SHORT;
                            end else if (match) begin
                                n_wrong = '0;
                                ev      = kcl_pkg::EV_UNLOCKED;
                            end else begin
                                n_wrong = wrong_inc;
                                if (wrong_inc >= r_max_err) begin
                                    n_lock      = 1'b1;
                                    n_lock_left = r_lock_sec;
                                    ev          = kcl_pkg::EV_LOCKED;
                                end else begin
                                    ev = kcl_pkg::EV_WRONG;
                                end
                            end
                        end else if (r_key == kcl_pkg::KEY_BACK) begin
                            if (r_entry_len != '0) begin
                                n_entry_len = r_entry_len - LW'(1);
                                ev          = kcl_pkg::EV_BACK;
                            end
                        end else if (r_key == kcl_pkg::KEY_ADMIN) begin
                            n_admin   = 1'b1;
                            n_new_len = '0;
                            n_idle    = '0;
                            ev        = kcl_pkg::EV_ADMIN_IN;
                        end
                    end
                end
            end
            kcl_pkg::MODE_TICK: begin
                // Count down the lockout, release on the tick after zero
                if (r_lock) begin
                    if (r_lock_left != '0) begin
                        n_lock_left = r_lock_left - kcl_pkg::SEC_W'(1);
                        ev          = kcl_pkg::EV_COUNTDOWN;
                    end else begin
                        n_lock  = 1'b0;
                        n_wrong = '0;
                        ev      = kcl_pkg::EV_RELEASED;
                    end
                end
            end
            kcl_pkg::MODE_IDLE_TICK: begin
                // Drop code change once idle long enough
                if (!r_lock && r_admin) begin
                    if (idle_inc >= r_idle_lim) begin
                        n_admin     = 1'b0;
                        n_new_len   = '0;
                        n_idle      = '0;
                        n_entry_len = '0;
                        ev          = kcl_pkg::EV_ADMIN_TIMEOUT;
                    end else begin
                        n_idle = idle_inc;
                    end
                end
            end
            default: begin
                ev = kcl_pkg::EV_NONE;
            end
        endcase
    end

    // Length shown in the result word
    assign shown_len     = n_admin ? n_new_len : n_entry_len;
    assign shown_len_ext = (LW + 3)'(shown_len);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_err  <= kcl_pkg::MAX_ERRORS_RST;
            r_lock_sec <= kcl_pkg::LOCK_SECONDS_RST;
            r_idle_lim <= kcl_pkg::ADMIN_IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kcl_pkg::CFG_MAX_ERRORS:       r_max_err  <= i_cfg_data[kcl_pkg::ERR_W-1:0];
                kcl_pkg::CFG_LOCK_SECONDS:     r_lock_sec <= i_cfg_data[kcl_pkg::SEC_W-1:0];
                kcl_pkg::CFG_ADMIN_IDLE_LIMIT: r_idle_lim <= i_cfg_data[kcl_pkg::SEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: load on accept, drop once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.key_code;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_len <= '0;
            r_new_len   <= '0;
            r_admin     <= 1'b0;
            r_idle      <= '0;
            r_wrong     <= '0;
            r_lock      <= 1'b0;
            r_lock_left <= '0;
        end else if (advance) begin
            r_entry_len <= n_entry_len;
            r_new_len   <= n_new_len;
            r_admin     <= n_admin;
            r_idle      <= n_idle;
            r_wrong     <= n_wrong;
            r_lock      <= n_lock;
            r_lock_left <= n_lock_left;
        end
    end

    // Stored code: default digits 1..6 after reset, replaced on update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CODE_LEN; i++) begin
                r_stored[i] <= (i < kcl_pkg::DEFAULT_CODE_DIGITS)
                               ? kcl_pkg::DIGIT_W'(i + 1) : '0;
            end
        end else if (advance && code_upd) begin
            for (int i = 0; i < CODE_LEN; i++) begin
                r_stored[i] <= r_new[i];
            end
        end
    end

    // Entry and new-code digits: write the slot at the current length
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CODE_LEN; i++) begin
            if (advance && wr_entry && r_entry_len == LW'(i)) begin
                r_entry[i] <= digit;
            end
            if (advance && wr_new && r_new_len == LW'(i)) begin
                r_new[i] <= digit;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ev        <= ev;
            r_count     <= shown_len_ext[kcl_pkg::COUNT_W-1:0];
            r_out_lock  <= n_lock;
            r_out_left  <= n_lock_left;
            r_out_admin <= n_admin;
            r_out_err   <= n_wrong;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.event_res      = r_ev;
    assign o_out.entry_count    = r_count;
    assign o_out.locked         = r_out_lock;
    assign o_out.lock_remaining = r_out_left;
    assign o_out.admin_active   = r_out_admin;
    assign o_out.errors_so_far  = r_out_err;

    // Lockout and code change never overlap
    a_lock_not_admin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> !r_admin)
        else $error("lockout active while in code change");

    // Digit counts stay within the code length
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_entry_len <= FULL_LEN) && (r_new_len <= FULL_LEN))
        else $error("digit count beyond code length");

    // Input stalls only with both registers full and the result stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_vld && r_out_vld && !o_out.ready))
        else $error("input stalled without a full pipeline");

    // A lock event leaves the block locked
    a_lock_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && ev == kcl_pkg::EV_LOCKED) |=> (r_lock && o_out.locked))
        else $error("lock event did not lock");

    // Released leaves the block unlocked with no errors counted
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && ev == kcl_pkg::EV_RELEASED) |=> (!r_lock && r_wrong == '0))
        else $error("release did not clear lockout");

endmodule
